/* rtl/core/spd_pkg.sv */
package spd_pkg;

  localparam int BYTE_W  = 8;
  localparam int KIND_W  = 2;
  localparam int COUNT_W = 6;

  localparam logic [BYTE_W-1:0] SENTINEL = 8'hFF;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_HEADER   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PARAM    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CSUM_ERR = 2'd2;
  localparam logic [KIND_W-1:0] KIND_LEN_ERR  = 2'd3;

  typedef enum logic [2:0] {
    ST_HUNT0,
    ST_HUNT1,
    ST_ID,
    ST_LEN,
    ST_INSTR,
    ST_PARAM,
    ST_CSUM,
    ST_EMIT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load_id;
    logic load_len;
    logic load_instr;
    logic load_param;
    logic out_hdr;
    logic out_csum_err;
    logic out_len_err;
    logic out_param;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic byte_is_sentinel;
    logic len_bad;
    logic count_zero;
    logic params_done;
    logic csum_ok;
    logic emit_last;
    logic out_free;
  } dp_stat_t;

endpackage

/* rtl/core/spd_ram.sv */
module spd_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 32,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/core/spd_ctrl.sv */
module spd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  spd_pkg::dp_stat_t stat,
  output spd_pkg::dp_cmd_t  cmd
);

  import spd_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_HUNT0;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    // Length and checksum bytes may produce a result: wait for a free slot.
    case (state_r)
      ST_EMIT:         in_ready = 1'b0;
      ST_LEN, ST_CSUM: in_ready = stat.out_free;
      default:         in_ready = 1'b1;
    endcase
    accept = in_valid && in_ready;

    case (state_r)
      ST_HUNT0: begin
        if (accept) begin
          state_nxt = stat.byte_is_sentinel ? ST_HUNT1 : ST_HUNT0;
        end
      end
      ST_HUNT1: begin
        if (accept) begin
          state_nxt = stat.byte_is_sentinel ? ST_ID : ST_HUNT0;
        end
      end
      ST_ID: begin
        if (accept) begin
          cmd.load_id = 1'b1;
          state_nxt   = ST_LEN;
        end
      end
      ST_LEN: begin
        if (accept) begin
          cmd.load_len = 1'b1;
          if (stat.len_bad) begin
            cmd.out_len_err = 1'b1;
            state_nxt       = ST_HUNT0;
          end else begin
            state_nxt = ST_INSTR;
          end
        end
      end
      ST_INSTR: begin
        if (accept) begin
          cmd.load_instr = 1'b1;
          state_nxt      = stat.count_zero ? ST_CSUM : ST_PARAM;
        end
      end
      ST_PARAM: begin
        if (accept) begin
          cmd.load_param = 1'b1;
          if (stat.params_done) begin
            state_nxt = ST_CSUM;
          end
        end
      end
      ST_CSUM: begin
        if (accept) begin
          if (stat.csum_ok) begin
            cmd.out_hdr = 1'b1;
            state_nxt   = stat.count_zero ? ST_HUNT0 : ST_EMIT;
          end else begin
            cmd.out_csum_err = 1'b1;
            state_nxt        = ST_HUNT0;
          end
        end
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.out_param = 1'b1;
          if (stat.emit_last) begin
            state_nxt = ST_HUNT0;
          end
        end
      end
      default: begin
        state_nxt = ST_HUNT0;
      end
    endcase
  end

endmodule

/* rtl/core/spd_dp.sv */
module spd_dp #(
  parameter int MAX_PARAMS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [spd_pkg::BYTE_W-1:0]  in_byte,
  input  spd_pkg::dp_cmd_t            cmd,
  output spd_pkg::dp_stat_t           stat,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic [spd_pkg::KIND_W-1:0]  out_kind,
  output logic [spd_pkg::BYTE_W-1:0]  out_id,
  output logic [spd_pkg::BYTE_W-1:0]  out_instr,
  output logic [spd_pkg::COUNT_W-1:0] out_count,
  output logic [spd_pkg::BYTE_W-1:0]  out_pbyte,
  output logic                        out_last
);

  import spd_pkg::*;

  localparam int ADDR_W = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
  localparam logic [BYTE_W-1:0] LEN_MAX = BYTE_W'(MAX_PARAMS + 2);

  logic [BYTE_W-1:0]  id_r;
  logic [BYTE_W-1:0]  instr_r;
  logic [BYTE_W-1:0]  sum_r;
  logic [COUNT_W-1:0] count_r;
  logic [COUNT_W-1:0] seen_r;
  logic [COUNT_W-1:0] rd_idx_r;
  logic [COUNT_W-1:0] rd_idx_nxt;
  logic [COUNT_W-1:0] len_m2;
  logic [COUNT_W:0]   seen_inc;
  logic [COUNT_W:0]   rd_inc;
  logic [BYTE_W-1:0]  ram_rdata;

  logic               out_valid_r;
  logic [KIND_W-1:0]  out_kind_r;
  logic [BYTE_W-1:0]  out_id_r;
  logic [BYTE_W-1:0]  out_instr_r;
  logic [COUNT_W-1:0] out_count_r;
  logic [BYTE_W-1:0]  out_pbyte_r;
  logic               out_last_r;
  logic               out_load;

  assign len_m2   = in_byte[COUNT_W-1:0] - COUNT_W'(2);
  assign seen_inc = {1'b0, seen_r} + (COUNT_W+1)'(1);
  assign rd_inc   = {1'b0, rd_idx_r} + (COUNT_W+1)'(1);

  assign stat.byte_is_sentinel = (in_byte == SENTINEL);
  assign stat.len_bad          = (in_byte < BYTE_W'(2)) || (in_byte > LEN_MAX);
  assign stat.count_zero       = (count_r == '0);
  assign stat.params_done      = (seen_inc >= {1'b0, count_r});
  assign stat.csum_ok          = (~sum_r == in_byte);
  assign stat.emit_last        = (rd_inc == {1'b0, count_r});
  assign stat.out_free         = !out_valid_r || out_ready;

  // Read address runs one step ahead so the registered read tracks rd_idx_r.
  always_comb begin
    rd_idx_nxt = rd_idx_r;
    if (cmd.load_instr) begin
      rd_idx_nxt = '0;
    end else if (cmd.out_param) begin
      rd_idx_nxt = rd_inc[COUNT_W-1:0];
    end
  end

  spd_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAX_PARAMS)
  ) u_store (
    .clk     (clk),
    .wr_en   (cmd.load_param),
    .wr_addr (seen_r[ADDR_W-1:0]),
    .wr_data (in_byte),
    .rd_addr (rd_idx_nxt[ADDR_W-1:0]),
    .rd_data (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r   <= '0;
      rd_idx_r <= '0;
    end else begin
      rd_idx_r <= rd_idx_nxt;
      if (cmd.load_instr) begin
        seen_r <= '0;
      end else if (cmd.load_param) begin
        seen_r <= seen_inc[COUNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_id) begin
      id_r  <= in_byte;
      sum_r <= in_byte;
    end
    if (cmd.load_len) begin
      count_r <= len_m2;
      sum_r   <= sum_r + in_byte;
    end
    if (cmd.load_instr) begin
      instr_r <= in_byte;
      sum_r   <= sum_r + in_byte;
    end
    if (cmd.load_param) begin
      sum_r <= sum_r + in_byte;
    end
  end

  // Output register
  assign out_load = cmd.out_hdr || cmd.out_csum_err || cmd.out_len_err || cmd.out_param;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_len_err) begin
      out_kind_r  <= KIND_LEN_ERR;
      out_id_r    <= id_r;
      out_instr_r <= '0;
      out_count_r <= '0;
      out_pbyte_r <= '0;
      out_last_r  <= 1'b1;
    end else if (cmd.out_hdr) begin
      out_kind_r  <= KIND_HEADER;
      out_id_r    <= id_r;
      out_instr_r <= instr_r;
      out_count_r <= count_r;
      out_pbyte_r <= '0;
      out_last_r  <= (count_r == '0);
    end else if (cmd.out_csum_err) begin
      out_kind_r  <= KIND_CSUM_ERR;
      out_id_r    <= id_r;
      out_instr_r <= instr_r;
      out_count_r <= count_r;
      out_pbyte_r <= '0;
      out_last_r  <= 1'b1;
    end else if (cmd.out_param) begin
      out_kind_r  <= KIND_PARAM;
      out_id_r    <= id_r;
      out_instr_r <= instr_r;
      out_count_r <= count_r;
      out_pbyte_r <= ram_rdata;
      out_last_r  <= stat.emit_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_id    = out_id_r;
  assign out_instr = out_instr_r;
  assign out_count = out_count_r;
  assign out_pbyte = out_pbyte_r;
  assign out_last  = out_last_r;

endmodule

/* rtl/core/servo_packet_deframer.sv */
// Servo bus packet deframer.
//
// Input stream: one received serial byte per transaction on in_tdata. The
// block hunts for two 0xFF sentinel bytes, then takes ID, length, instruction,
// length-2 parameter bytes and the checksum (inverted 8-bit sum of ID through
// the last parameter).
// Result stream: a good packet gives a header transaction (tuser 0) followed
// by one transaction per parameter byte (tuser 1), tlast on the final one. A
// bad checksum gives one checksum-error transaction (tuser 2); a length below
// 2 or a parameter count above MAX_PARAMS gives one length-error transaction
// (tuser 3). Both then hunt again.
// Throughput: one byte per cycle while parsing, unless stalled as below. On a
// good checksum with parameters, in_tready stays low while the parameters are
// read out of the parameter store, one per cycle while out_tready is high.
// The first result is registered and shows in the cycle after the checksum byte.
// Stalls: a waiting result does not block sentinel, ID, instruction or
// parameter bytes; length and checksum bytes wait for a free output slot, and
// the parameter burst advances only as out_tready takes each transaction.
// Reset (rst_n low, synchronous) returns to the hunt and empties the output.
module servo_packet_deframer #(
  parameter int MAX_PARAMS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [7:0] packet_id, [15:8] instruction,
                                  // [21:16] param_count, [29:22] param_byte,
                                  // [31:30] zero
  output logic [1:0]  out_tuser,  // [1:0] kind
  output logic        out_tlast
);

  import spd_pkg::*;

  dp_cmd_t            cmd;
  dp_stat_t           stat;
  logic [BYTE_W-1:0]  res_id;
  logic [BYTE_W-1:0]  res_instr;
  logic [COUNT_W-1:0] res_count;
  logic [BYTE_W-1:0]  res_pbyte;

  // Sequence the packet fields and the parameter burst.
  spd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Hold packet fields, checksum, parameter store and the output register.
  spd_dp #(
    .MAX_PARAMS (MAX_PARAMS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_byte   (in_tdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_kind  (out_tuser),
    .out_id    (res_id),
    .out_instr (res_instr),
    .out_count (res_count),
    .out_pbyte (res_pbyte),
    .out_last  (out_tlast)
  );

  assign out_tdata = {2'b00, res_pbyte, res_count, res_instr, res_id};

endmodule
